FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is low
`define LFS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also checks during reset
`define LFS_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/lfs_pkg.sv
// Shared types and constants for the line follower steering controller
`default_nettype none
package lfs_pkg;

  localparam int unsigned SENSOR_COUNT = 8;
  localparam int unsigned SENSOR_IDX_W = 3;
  localparam int unsigned LEVEL_W      = 10;
  localparam int unsigned DUTY_W       = 16;
  localparam int unsigned Q8_W         = 8;
  localparam int unsigned PROD_W       = DUTY_W + Q8_W;

  typedef logic [1:0]          cmd_t;
  typedef logic [1:0]          dir_t;
  typedef logic [LEVEL_W-1:0]  level_t;
  typedef logic [DUTY_W-1:0]   duty_t;
  typedef logic [Q8_W-1:0]     q8_t;

  localparam cmd_t CMD_SAMPLE = 2'd0;
  localparam cmd_t CMD_TICK   = 2'd1;
  localparam cmd_t CMD_START  = 2'd2;
  localparam cmd_t CMD_STOP   = 2'd3;

  localparam dir_t DIR_OFF = 2'd0;
  localparam dir_t DIR_FWD = 2'd1;
  localparam dir_t DIR_REV = 2'd2;

  localparam q8_t Q8_090 = 8'd230;
  localparam q8_t Q8_070 = 8'd179;
  localparam q8_t Q8_040 = 8'd102;
  localparam q8_t Q8_020 = 8'd51;

  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_FULL_DUTY = 1'b1;

  localparam level_t THRESHOLD_RST = 10'd700;
  localparam duty_t  FULL_DUTY_RST = 16'd14746;

  localparam int unsigned CH_LSB  = 24;
  localparam int unsigned VAL_LSB = 6;

  typedef struct packed {
    duty_t duty_a;
    duty_t duty_b;
    dir_t  dir_a;
    dir_t  dir_b;
    logic  last_left;
  } steer_t;

endpackage
`default_nettype wire

FILE: hw/rtl/lfs_steer.sv
// Priority steering decision and duty scaling for one control tick
`default_nettype none
module lfs_steer (
  input  wire logic [lfs_pkg::SENSOR_COUNT-1:0] sees,
  input  wire logic                             last_left,
  input  wire lfs_pkg::dir_t                    dir_a,
  input  wire lfs_pkg::dir_t                    dir_b,
  input  wire lfs_pkg::duty_t                   full_duty,
  output lfs_pkg::steer_t                       steer
);
  import lfs_pkg::*;

  logic              scale_a;
  logic              scale_b;
  q8_t               factor;
  logic [PROD_W-1:0] prod;
  duty_t             scaled;

  always_comb begin
    scale_a         = 1'b0;
    scale_b         = 1'b0;
    factor          = Q8_020;
    steer.dir_a     = dir_a;
    steer.dir_b     = dir_b;
    steer.last_left = last_left;
    if (sees[3] && sees[4]) begin
      steer.dir_a = DIR_FWD;
      steer.dir_b = DIR_FWD;
    end else if (sees[3]) begin
      steer.dir_a = DIR_FWD;
      steer.dir_b = DIR_FWD;
      scale_b     = 1'b1;
      factor      = Q8_090;
    end else if (sees[4]) begin
      steer.dir_a = DIR_FWD;
      steer.dir_b = DIR_FWD;
      scale_a     = 1'b1;
      factor      = Q8_090;
    end else if (sees[2]) begin
      steer.dir_a     = DIR_FWD;
      steer.dir_b     = DIR_FWD;
      scale_b         = 1'b1;
      factor          = Q8_070;
      steer.last_left = 1'b0;
    end else if (sees[5]) begin
      steer.dir_a     = DIR_FWD;
      steer.dir_b     = DIR_FWD;
      scale_a         = 1'b1;
      factor          = Q8_070;
      steer.last_left = 1'b1;
    end else if (sees[1]) begin
      steer.dir_a     = DIR_FWD;
      steer.dir_b     = DIR_FWD;
      scale_b         = 1'b1;
      factor          = Q8_040;
      steer.last_left = 1'b0;
    end else if (sees[6]) begin
      steer.dir_a     = DIR_FWD;
      steer.dir_b     = DIR_FWD;
      scale_a         = 1'b1;
      factor          = Q8_040;
      steer.last_left = 1'b1;
    end else if (sees[0]) begin
      steer.dir_b     = DIR_FWD;
      scale_b         = 1'b1;
      steer.last_left = 1'b0;
    end else if (sees[7]) begin
      steer.dir_a     = DIR_FWD;
      scale_a         = 1'b1;
      steer.last_left = 1'b1;
    end else if (!last_left) begin
      steer.dir_a = DIR_REV;
      steer.dir_b = DIR_FWD;
      scale_b     = 1'b1;
    end else begin
      steer.dir_a = DIR_FWD;
      steer.dir_b = DIR_REV;
      scale_a     = 1'b1;
    end
    prod         = PROD_W'(full_duty) * PROD_W'(factor);
    scaled       = prod[PROD_W-1:Q8_W];
    steer.duty_a = scale_a ? scaled : full_duty;
    steer.duty_b = scale_b ? scaled : full_duty;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/line_follower_steering_controller_core.sv
// Top level of the line follower steering controller
//
//   channel | signals                                   | beat
//   --------+-------------------------------------------+--------------------------
//   in      | in_valid/in_ready, in_cmd, in_raw_word     | one event
//   out     | out_valid/out_ready, out_duty_*, out_dir_* | duties and directions
//   cfg     | cfg_we, cfg_index, cfg_wdata               | one register write
//
// One event per cycle: an input register feeds the decision logic and the
// result register. A stop or a tick while tracking yields one beat through
// both registers; sample, start and idle ticks yield none. Input stalls only
// while a beat waits in the result register and the next event needs it.
// Synchronous reset clears the sensor store, the mode and the directions.
`default_nettype none
module line_follower_steering_controller_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire lfs_pkg::cmd_t  in_cmd,
  input  wire logic [31:0]    in_raw_word,
  output logic                out_valid,
  input  wire logic           out_ready,
  output lfs_pkg::duty_t      out_duty_a,
  output lfs_pkg::duty_t      out_duty_b,
  output lfs_pkg::dir_t       out_dir_a,
  output lfs_pkg::dir_t       out_dir_b,
  input  wire logic           cfg_we,
  input  wire logic           cfg_index,
  input  wire logic [15:0]    cfg_wdata
);
  import lfs_pkg::*;

  logic                    thr_en;
  logic                    full_en;
  level_t                  threshold_r;
  duty_t                   full_duty_r;

  logic                    s1_valid_r,  s1_valid_nxt;
  cmd_t                    s1_cmd_r;
  logic [SENSOR_IDX_W-1:0] s1_ch_r;
  level_t                  s1_val_r;

  level_t                  levels_r [SENSOR_COUNT];
  logic                    tracking_r, tracking_nxt;
  logic                    last_left_r, last_left_nxt;
  dir_t                    dir_a_r, dir_a_nxt;
  dir_t                    dir_b_r, dir_b_nxt;

  logic                    out_valid_r, out_valid_nxt;
  duty_t                   duty_a_r, duty_a_nxt;
  duty_t                   duty_b_r, duty_b_nxt;
  dir_t                    odir_a_r, odir_a_nxt;
  dir_t                    odir_b_r, odir_b_nxt;

  logic [SENSOR_COUNT-1:0] sees;
  steer_t                  steer;
  logic                    in_fire;
  logic                    need_out;
  logic                    out_free;
  logic                    s1_adv;
  logic                    load_out;
  logic                    store_en;

  // configuration registers
  assign thr_en  = cfg_we && (cfg_index == CFG_THRESHOLD);
  assign full_en = cfg_we && (cfg_index == CFG_FULL_DUTY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RST;
      full_duty_r <= FULL_DUTY_RST;
    end else begin
      if (thr_en) begin
        threshold_r <= cfg_wdata[LEVEL_W-1:0];
      end
      if (full_en) begin
        full_duty_r <= cfg_wdata;
      end
    end
  end

  // handshake
  assign in_fire  = in_valid && in_ready;
  assign need_out = (s1_cmd_r == CMD_STOP) || ((s1_cmd_r == CMD_TICK) && tracking_r);
  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && (!need_out || out_free);
  assign in_ready = !s1_valid_r || s1_adv;
  assign load_out = s1_adv && need_out;
  assign store_en = s1_adv && (s1_cmd_r == CMD_SAMPLE);

  assign s1_valid_nxt = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r <= in_cmd;
      s1_ch_r  <= in_raw_word[CH_LSB +: SENSOR_IDX_W];
      s1_val_r <= in_raw_word[VAL_LSB +: LEVEL_W];
    end
  end

  // sensor store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        levels_r[i] <= '0;
      end
    end else if (store_en) begin
      levels_r[s1_ch_r] <= s1_val_r;
    end
  end

  always_comb begin
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      sees[i] = levels_r[i] > threshold_r;
    end
  end

  lfs_steer u_steer (
    .sees      (sees),
    .last_left (last_left_r),
    .dir_a     (dir_a_r),
    .dir_b     (dir_b_r),
    .full_duty (full_duty_r),
    .steer     (steer)
  );

  // mode, turn memory and motor directions
  always_comb begin
    tracking_nxt  = tracking_r;
    last_left_nxt = last_left_r;
    dir_a_nxt     = dir_a_r;
    dir_b_nxt     = dir_b_r;
    if (s1_adv) begin
      unique case (s1_cmd_r)
        CMD_START: begin
          tracking_nxt = 1'b1;
        end
        CMD_STOP: begin
          tracking_nxt = 1'b0;
        end
        CMD_TICK: begin
          if (tracking_r) begin
            last_left_nxt = steer.last_left;
            dir_a_nxt     = steer.dir_a;
            dir_b_nxt     = steer.dir_b;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tracking_r  <= 1'b0;
      last_left_r <= 1'b0;
      dir_a_r     <= DIR_OFF;
      dir_b_r     <= DIR_OFF;
    end else begin
      tracking_r  <= tracking_nxt;
      last_left_r <= last_left_nxt;
      dir_a_r     <= dir_a_nxt;
      dir_b_r     <= dir_b_nxt;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    duty_a_nxt    = duty_a_r;
    duty_b_nxt    = duty_b_r;
    odir_a_nxt    = odir_a_r;
    odir_b_nxt    = odir_b_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      if (s1_cmd_r == CMD_STOP) begin
        duty_a_nxt = '0;
        duty_b_nxt = '0;
        odir_a_nxt = dir_a_r;
        odir_b_nxt = dir_b_r;
      end else begin
        duty_a_nxt = steer.duty_a;
        duty_b_nxt = steer.duty_b;
        odir_a_nxt = steer.dir_a;
        odir_b_nxt = steer.dir_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    duty_a_r <= duty_a_nxt;
    duty_b_r <= duty_b_nxt;
    odir_a_r <= odir_a_nxt;
    odir_b_r <= odir_b_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_duty_a = duty_a_r;
  assign out_duty_b = duty_b_r;
  assign out_dir_a  = odir_a_r;
  assign out_dir_b  = odir_b_r;

endmodule
`default_nettype wire

FILE: hw/rtl/lfs_checker.sv
// Port-level checks for the steering controller, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module lfs_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_ready,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire lfs_pkg::dir_t out_dir_a,
  input wire lfs_pkg::dir_t out_dir_b
);
  import lfs_pkg::*;

  `LFS_ASSERT_RST(a_reset_drops_out, clk, !rst_n |=> !out_valid, "out beat after reset")
  `LFS_ASSERT_RST(a_ready_after_reset, clk, !rst_n |=> in_ready, "input stalled after reset")
  `LFS_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "out beat dropped")
  `LFS_ASSERT(a_no_double_rev, clk, rst_n, out_valid |-> !(out_dir_a == DIR_REV && out_dir_b == DIR_REV), "both motors reverse")

endmodule

bind line_follower_steering_controller_core lfs_checker u_lfs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_dir_a (out_dir_a),
  .out_dir_b (out_dir_b)
);
`default_nettype wire

FILE: verif/tb_line_follower_steering_controller_core.sv
// Testbench for the line follower steering controller: random events, predicted steering beats
`default_nettype none
module tb_line_follower_steering_controller_core;
  import lfs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned PHASE_COUNT = 6;
  localparam int unsigned ITEMS_PER_PHASE = 105;

  typedef struct packed {
    duty_t duty_a;
    duty_t duty_b;
    dir_t  dir_a;
    dir_t  dir_b;
  } steer_beat_t;

  class steer_scoreboard;
    level_t      thresh;
    duty_t       full;
    level_t      levels[SENSOR_COUNT];
    bit          tracking;
    bit          turn_left;
    dir_t        mot_a;
    dir_t        mot_b;
    steer_beat_t steer_q[$];
    int unsigned mismatches;

    function new();
      thresh = THRESHOLD_RST;
      full = FULL_DUTY_RST;
      foreach (levels[i]) levels[i] = '0;
      tracking = 1'b0;
      turn_left = 1'b0;
      mot_a = DIR_OFF;
      mot_b = DIR_OFF;
      mismatches = 0;
    endfunction

    function void write_reg(logic idx, logic [15:0] data);
      if (idx == CFG_THRESHOLD) thresh = data[LEVEL_W-1:0];
      else full = data;
    endfunction

    function int unsigned pending();
      return steer_q.size();
    endfunction

    function duty_t scale(q8_t f);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(full) * PROD_W'(f);
      return prod[PROD_W-1:Q8_W];
    endfunction

    function bit sees(int unsigned ch);
      return levels[ch] > thresh;
    endfunction

    function void steer(output duty_t da, output duty_t db);
      if (sees(3) && sees(4)) begin
        mot_a = DIR_FWD; mot_b = DIR_FWD; da = full; db = full;
      end else if (sees(3)) begin
        mot_a = DIR_FWD; mot_b = DIR_FWD; da = full; db = scale(Q8_090);
      end else if (sees(4)) begin
        mot_a = DIR_FWD; mot_b = DIR_FWD; da = scale(Q8_090); db = full;
      end else if (sees(2)) begin
        mot_a = DIR_FWD; mot_b = DIR_FWD; da = full; db = scale(Q8_070); turn_left = 1'b0;
      end else if (sees(5)) begin
        mot_a = DIR_FWD; mot_b = DIR_FWD; da = scale(Q8_070); db = full; turn_left = 1'b1;
      end else if (sees(1)) begin
        mot_a = DIR_FWD; mot_b = DIR_FWD; da = full; db = scale(Q8_040); turn_left = 1'b0;
      end else if (sees(6)) begin
        mot_a = DIR_FWD; mot_b = DIR_FWD; da = scale(Q8_040); db = full; turn_left = 1'b1;
      end else if (sees(0)) begin
        mot_b = DIR_FWD; da = full; db = scale(Q8_020); turn_left = 1'b0;
      end else if (sees(7)) begin
        mot_a = DIR_FWD; da = scale(Q8_020); db = full; turn_left = 1'b1;
      end else if (!turn_left) begin
        mot_a = DIR_REV; mot_b = DIR_FWD; da = full; db = scale(Q8_020);
      end else begin
        mot_a = DIR_FWD; mot_b = DIR_REV; da = scale(Q8_020); db = full;
      end
    endfunction

    function void note_event(cmd_t cmd, logic [31:0] word);
      duty_t da;
      duty_t db;
      case (cmd)
        CMD_SAMPLE: begin
          levels[word[CH_LSB +: SENSOR_IDX_W]] = word[VAL_LSB +: LEVEL_W];
        end
        CMD_START: begin
          tracking = 1'b1;
        end
        CMD_STOP: begin
          tracking = 1'b0;
          steer_q.push_back('{duty_a: '0, duty_b: '0, dir_a: mot_a, dir_b: mot_b});
        end
        default: begin
          if (tracking) begin
            steer(da, db);
            steer_q.push_back('{duty_a: da, duty_b: db, dir_a: mot_a, dir_b: mot_b});
          end
        end
      endcase
    endfunction

    function void check_beat(duty_t da, duty_t db, dir_t a, dir_t b);
      steer_beat_t exp_beat;
      if (steer_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: duty_a=%0d duty_b=%0d dir_a=%0d dir_b=%0d",
                   da, db, a, b);
        return;
      end
      exp_beat = steer_q.pop_front();
      if (exp_beat.duty_a !== da || exp_beat.duty_b !== db ||
          exp_beat.dir_a !== a || exp_beat.dir_b !== b) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp duty_a=%0d duty_b=%0d dir_a=%0d dir_b=%0d, got %0d %0d %0d %0d",
                   exp_beat.duty_a, exp_beat.duty_b, exp_beat.dir_a, exp_beat.dir_b,
                   da, db, a, b);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  cmd_t        in_cmd;
  logic [31:0] in_raw_word;
  logic        out_valid;
  logic        out_ready;
  duty_t       out_duty_a;
  duty_t       out_duty_b;
  dir_t        out_dir_a;
  dir_t        out_dir_b;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_wdata;

  steer_scoreboard sb = new();
  bit              hold_req = 1'b0;
  bit              no_idle = 1'b0;
  int unsigned     cycle_count = 0;

  line_follower_steering_controller_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_cmd     (in_cmd),
    .in_raw_word(in_raw_word),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_duty_a (out_duty_a),
    .out_duty_b (out_duty_b),
    .out_dir_a  (out_dir_a),
    .out_dir_b  (out_dir_b),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_event(in_cmd, in_raw_word);
    if (rst_n && out_valid && out_ready)
      sb.check_beat(out_duty_a, out_duty_b, out_dir_a, out_dir_b);
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] sample_word(logic [2:0] ch, level_t v);
    logic [31:0] w;
    w = $urandom;
    w[CH_LSB +: SENSOR_IDX_W] = ch;
    w[VAL_LSB +: LEVEL_W] = v;
    return w;
  endfunction

  function automatic level_t pick_level();
    int unsigned r;
    int unsigned t;
    r = $urandom_range(0, 99);
    t = sb.thresh;
    if (r < 10) return '0;
    if (r < 18) return '1;
    if (r < 30) return level_t'(t);
    if (r < 42) return (t == 1023) ? level_t'(t) : level_t'(t + 1);
    if (r < 50) return (t == 0) ? '0 : level_t'(t - 1);
    if (r < 75) return level_t'($urandom_range(0, t));
    return level_t'($urandom_range(0, 1023));
  endfunction

  // receiver: random stalls, long hold on request
  initial begin
    int unsigned g;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        g = gap_len();
        out_ready = (g == 0);
        if (g > 1) repeat (g - 1) @(negedge clk);
      end
    end
  end

  task automatic send_beat(cmd_t c, logic [31:0] w);
    int unsigned g;
    in_valid = 1'b1;
    in_cmd = c;
    in_raw_word = w;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    g = gap_len();
    if (g > 0) begin
      in_valid = 1'b0;
      in_cmd = cmd_t'($urandom);
      in_raw_word = $urandom;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] data);
    drain();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_random();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) send_beat(CMD_SAMPLE, sample_word(3'($urandom), pick_level()));
    else if (r < 88) send_beat(CMD_TICK, $urandom);
    else if (r < 94) send_beat(CMD_START, $urandom);
    else send_beat(CMD_STOP, $urandom);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_SAMPLE;
    in_raw_word = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_THRESHOLD;
    cfg_wdata = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_beat(CMD_TICK, $urandom);
    send_beat(CMD_STOP, $urandom);
    send_beat(CMD_START, $urandom);
    send_beat(CMD_TICK, 32'h0);
    for (int unsigned ch = 0; ch < SENSOR_COUNT; ch++) begin
      if (ch == 7) send_beat(CMD_SAMPLE, 32'hFFFF_FFFF);
      else send_beat(CMD_SAMPLE, sample_word(3'(ch), '1));
      send_beat(CMD_TICK, $urandom);
      if (ch == 0) send_beat(CMD_SAMPLE, 32'h0);
      else send_beat(CMD_SAMPLE, sample_word(3'(ch), '0));
    end
    send_beat(CMD_TICK, 32'hFFFF_FFFF);
    send_beat(CMD_SAMPLE, sample_word(3'd3, 10'd701));
    send_beat(CMD_SAMPLE, sample_word(3'd4, 10'd700));
    send_beat(CMD_TICK, $urandom);
    send_beat(CMD_STOP, $urandom);
    send_beat(CMD_START, $urandom);

    for (int unsigned p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        1: begin
          write_reg(CFG_THRESHOLD, 16'hFC00);
          write_reg(CFG_FULL_DUTY, 16'hFFFF);
          no_idle = 1'b1;
        end
        2: begin
          no_idle = 1'b0;
          write_reg(CFG_THRESHOLD, 16'h03FF);
          write_reg(CFG_FULL_DUTY, 16'h0000);
        end
        3: begin
          write_reg(CFG_THRESHOLD, {6'($urandom), 10'd1});
          write_reg(CFG_FULL_DUTY, 16'd1);
        end
        4, 5: begin
          write_reg(CFG_THRESHOLD, 16'($urandom));
          write_reg(CFG_FULL_DUTY, 16'($urandom));
        end
        default: begin
        end
      endcase
      for (int unsigned i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i == 30 && (p == 0 || p == 5)) hold_req = 1'b1;
        send_random();
      end
    end

    drain();
    repeat (10) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
`default_nettype wire
